// File: design/mlkcc_pkg.sv
`timescale 1ns / 1ps

package mlkcc_pkg;

  // Modulus and compress rounding constants
  localparam int unsigned KyberQ = 3329;
  localparam logic [11:0] QConst = 12'(KyberQ);
  // ceil(2^29 / q): floor(num * RecipM >> 30) == floor(num / 2q) for num < 2^21
  localparam logic [17:0] RecipM = 18'd161271;
  localparam int unsigned RecipShift = 30;

  // Configuration register indexes
  typedef enum logic {
    CFG_DIRECTION = 1'b0,
    CFG_BIT_MODE  = 1'b1
  } cfg_idx_t;

  // Bit-mode codes
  localparam logic [1:0] MODE_D1 = 2'd0;
  localparam logic [1:0] MODE_D4 = 2'd1;
  localparam logic [1:0] MODE_D5 = 2'd2;

  // Bits per coefficient for a mode code; the unused code behaves as 5 bits
  function automatic logic [2:0] bits_of(input logic [1:0] mode);
    logic [2:0] d;
    case (mode)
      MODE_D1: d = 3'd1;
      MODE_D4: d = 3'd4;
      default: d = 3'd5;
    endcase
    return d;
  endfunction

  // Low-d-bit mask
  function automatic logic [4:0] mask_of(input logic [1:0] mode);
    logic [4:0] m;
    case (mode)
      MODE_D1: m = 5'h01;
      MODE_D4: m = 5'h0F;
      default: m = 5'h1F;
    endcase
    return m;
  endfunction

endpackage

// File: design/mlkem_coeff_compress_pack.sv
`timescale 1ns / 1ps

// ML-KEM coefficient codec (q = 3329, 1, 4 or 5 bits per coefficient).
// Input channel: in_valid / in_stall carry one coefficient (compress) or one
// packed byte (decompress) per beat. Output channel: out_valid / out_stall
// carry one result per beat: a packed byte (compress) or a coefficient
// (decompress); out_last marks the final result of an input beat.
// An accepted beat is held in the input register, and its first result is
// registered from there into the output register, which then offers it.
// Compress: one coefficient per cycle while the output is not stalled, and a
// byte emerges every 8 bits' worth. Decompress: one coefficient per cycle out
// of the bit buffer while the output is not stalled; a byte holds the input
// register until the buffer drains below d bits.
// Writing either configuration register drops any pending bits.
// Reset (synchronous, rst_n low) empties both stages and the bit buffer and
// selects compress direction with 4 bits per coefficient.
// A stalled output holds its beat; the input register then holds too and
// in_stall rises, so nothing is lost or repeated.
module mlkem_coeff_compress_pack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_coefficient_in,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic        out_byte_valid,
  output logic [11:0] out_coefficient_out,
  output logic        out_coefficient_valid,
  output logic        out_last
);

  logic        direction_r;
  logic [1:0]  bit_mode_r;
  logic [11:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;

  logic        s1_valid_r;
  logic [11:0] s1_coef_r;
  logic [7:0]  s1_byte_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bvld_r, out_bvld_nxt;
  logic [11:0] out_coef_r, out_coef_nxt;
  logic        out_cvld_r, out_cvld_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2:0]  d_w;
  logic [3:0]  d4_w;
  logic [4:0]  mask_w;
  logic        adv_w, take_w, drain_w, in_acc_w, emit_w;

  // Compress datapath
  logic [18:0] num_w;
  logic [36:0] prod_w;
  logic [4:0]  cval_w;
  logic [11:0] cbuf_w;
  logic [3:0]  ccnt_w;

  // Decompress datapath
  logic [11:0] src_buf_w;
  logic [3:0]  src_cnt_w;
  logic [4:0]  y_w;
  logic [16:0] dval_w;
  logic [3:0]  dcnt_w;

  assign d_w    = mlkcc_pkg::bits_of(bit_mode_r);
  assign d4_w   = {1'b0, d_w};
  assign mask_w = mlkcc_pkg::mask_of(bit_mode_r);

  // Handshake: output register advances when empty or taken
  assign adv_w    = !out_valid_r || !out_stall;
  assign take_w   = s1_valid_r && adv_w && (!direction_r || (bit_count_r < d4_w));
  assign drain_w  = adv_w && direction_r && (bit_count_r >= d4_w);
  assign in_stall = s1_valid_r && !take_w;
  assign in_acc_w = in_valid && !in_stall;

  // Compress: round(2^d x / q) = floor((2^(d+1) x + q) / 2q), then pack
  always_comb begin
    case (bit_mode_r)
      mlkcc_pkg::MODE_D1: num_w = {5'b0, s1_coef_r, 2'b0};
      mlkcc_pkg::MODE_D4: num_w = {2'b0, s1_coef_r, 5'b0};
      default:            num_w = {1'b0, s1_coef_r, 6'b0};
    endcase
    num_w  = num_w + {7'b0, mlkcc_pkg::QConst};
    prod_w = 37'(num_w) * 37'(mlkcc_pkg::RecipM);
    cval_w = prod_w[mlkcc_pkg::RecipShift +: 5] & mask_w;
    cbuf_w = bit_buffer_r | (12'(cval_w) << bit_count_r);
    ccnt_w = bit_count_r + d4_w;
  end

  // Decompress: merge a new byte or drain the buffer, one value a beat
  always_comb begin
    if (take_w) begin
      src_buf_w = bit_buffer_r | (12'(s1_byte_r) << bit_count_r);
      src_cnt_w = bit_count_r + 4'd8;
    end else begin
      src_buf_w = bit_buffer_r;
      src_cnt_w = bit_count_r;
    end
    y_w    = src_buf_w[4:0] & mask_w;
    dval_w = (17'(y_w) * 17'(mlkcc_pkg::QConst) + (17'd1 << (d_w - 3'd1))) >> d_w;
    dcnt_w = src_cnt_w - d4_w;
  end

  // Next state of the buffer and the output register
  always_comb begin
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    emit_w         = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_bvld_nxt   = out_bvld_r;
    out_coef_nxt   = out_coef_r;
    out_cvld_nxt   = out_cvld_r;
    out_last_nxt   = out_last_r;
    if (!direction_r) begin
      if (take_w) begin
        out_byte_nxt = cbuf_w[7:0];
        out_bvld_nxt = 1'b1;
        out_coef_nxt = '0;
        out_cvld_nxt = 1'b0;
        out_last_nxt = 1'b1;
        if (ccnt_w >= 4'd8) begin
          emit_w         = 1'b1;
          bit_buffer_nxt = cbuf_w >> 8;
          bit_count_nxt  = ccnt_w - 4'd8;
        end else begin
          bit_buffer_nxt = cbuf_w;
          bit_count_nxt  = ccnt_w;
        end
      end
    end else if (take_w || drain_w) begin
      emit_w         = 1'b1;
      out_byte_nxt   = '0;
      out_bvld_nxt   = 1'b0;
      out_coef_nxt   = dval_w[11:0];
      out_cvld_nxt   = 1'b1;
      out_last_nxt   = dcnt_w < d4_w;
      bit_buffer_nxt = src_buf_w >> d_w;
      bit_count_nxt  = dcnt_w;
    end
    if (adv_w) begin
      out_valid_nxt = emit_w;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state: configuration, buffer, stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= 1'b0;
      bit_mode_r   <= mlkcc_pkg::MODE_D4;
      bit_buffer_r <= '0;
      bit_count_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (mlkcc_pkg::cfg_idx_t'(cfg_index))
          mlkcc_pkg::CFG_DIRECTION: direction_r <= cfg_data[0];
          mlkcc_pkg::CFG_BIT_MODE:  bit_mode_r  <= cfg_data;
          default:                  bit_mode_r  <= bit_mode_r;
        endcase
        bit_buffer_r <= '0;
        bit_count_r  <= '0;
      end else begin
        bit_buffer_r <= bit_buffer_nxt;
        bit_count_r  <= bit_count_nxt;
      end
      if (in_acc_w) begin
        s1_valid_r <= 1'b1;
      end else if (take_w) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc_w) begin
      s1_coef_r <= in_coefficient_in;
      s1_byte_r <= in_byte_in;
    end
    out_byte_r <= out_byte_nxt;
    out_bvld_r <= out_bvld_nxt;
    out_coef_r <= out_coef_nxt;
    out_cvld_r <= out_cvld_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_byte_out          = out_byte_r;
  assign out_byte_valid        = out_bvld_r;
  assign out_coefficient_out   = out_coef_r;
  assign out_coefficient_valid = out_cvld_r;
  assign out_last              = out_last_r;

endmodule

// File: sim/tb_mlkem_coeff_compress_pack.sv
`timescale 1ns / 1ps

module tb_mlkem_coeff_compress_pack;

  // Register values not named in the package
  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam logic [1:0] DIR_DECOMPRESS = 2'd1;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 50000;
  localparam int unsigned MAX_REPORTS   = 10;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        byte_flag;
    logic [11:0] coef_val;
    logic        coef_flag;
    logic        last_flag;
  } codec_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  mlkcc_pkg::cfg_idx_t   cfg_index = mlkcc_pkg::CFG_DIRECTION;
  logic [1:0]            cfg_data = 2'd0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [11:0]           in_coefficient_in = 12'd0;
  logic [7:0]            in_byte_in = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte_out;
  logic                  out_byte_valid;
  logic [11:0]           out_coefficient_out;
  logic                  out_coefficient_valid;
  logic                  out_last;

  // Mirror of the codec state and registers
  logic        pred_dir;
  logic [1:0]  pred_mode;
  int unsigned pred_buf;
  int unsigned pred_cnt;

  codec_result_t owed_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holdoff_req = 0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned compress_beats = 0;
  int unsigned decompress_beats = 0;
  int unsigned bytes_seen = 0;
  int unsigned coefs_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned input_stall_cycles = 0;

  mlkem_coeff_compress_pack u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_coefficient_in     (in_coefficient_in),
    .in_byte_in            (in_byte_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_out          (out_byte_out),
    .out_byte_valid        (out_byte_valid),
    .out_coefficient_out   (out_coefficient_out),
    .out_coefficient_valid (out_coefficient_valid),
    .out_last              (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bits per coefficient; the spare mode code packs 5 bits
  function automatic int unsigned coef_bits(input logic [1:0] mode);
    case (mode)
      mlkcc_pkg::MODE_D1: return 1;
      mlkcc_pkg::MODE_D4: return 4;
      default: return 5;
    endcase
  endfunction

  // Advance the mirrored bit buffer by one accepted beat and queue its results
  function automatic void predict_codec_beat(input logic [11:0] coef, input logic [7:0] pk);
    int unsigned d;
    int unsigned mask;
    int unsigned num;
    int unsigned y;
    int n;
    codec_result_t res[8];
    d = coef_bits(pred_mode);
    mask = (1 << d) - 1;
    n = 0;
    if (!pred_dir) begin
      // round(2^d x / q) = floor((2^(d+1) x + q) / 2q), wrapped to d bits
      num = (32'(coef) << (d + 1)) + mlkcc_pkg::KyberQ;
      pred_buf = (pred_buf | (((num / (2 * mlkcc_pkg::KyberQ)) & mask) << pred_cnt))
                 & 32'hFFF;
      pred_cnt += d;
      if (pred_cnt >= 8) begin
        owed_results.push_back('{byte_val: 8'(pred_buf), byte_flag: 1'b1,
                                 coef_val: 12'd0, coef_flag: 1'b0, last_flag: 1'b1});
        pred_buf >>= 8;
        pred_cnt -= 8;
      end
    end else begin
      pred_buf = (pred_buf | (32'(pk) << pred_cnt)) & 32'hFFF;
      pred_cnt += 8;
      while (pred_cnt >= d && n < 8) begin
        y = pred_buf & mask;
        res[n] = '{byte_val: 8'd0, byte_flag: 1'b0,
                   coef_val: 12'((mlkcc_pkg::KyberQ * y + (1 << (d - 1))) >> d),
                   coef_flag: 1'b1, last_flag: 1'b0};
        pred_buf >>= d;
        pred_cnt -= d;
        n++;
      end
      res[n - 1].last_flag = 1'b1;
      for (int i = 0; i < n; i++) owed_results.push_back(res[i]);
    end
  endfunction

  // Drive the output stall: a requested hold-off first, then random stalls
  always @(posedge clk) begin
    if (holdoff_req != 0) begin
      hold_left = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest owed result
  always @(posedge clk) begin
    codec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_byte_valid) bytes_seen++;
      if (out_coefficient_valid) coefs_seen++;
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing owed: byte=%0h coef=%0d last=%0b",
                   $realtime, out_byte_out, out_coefficient_out, out_last);
      end else begin
        want = owed_results.pop_front();
        if (out_byte_out !== want.byte_val || out_byte_valid !== want.byte_flag ||
            out_coefficient_out !== want.coef_val ||
            out_coefficient_valid !== want.coef_flag || out_last !== want.last_flag) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected byte=%0h bv=%0b coef=%0d cv=%0b last=%0b",
                     $realtime, want.byte_val, want.byte_flag, want.coef_val,
                     want.coef_flag, want.last_flag);
            $display("%0t:           actual byte=%0h bv=%0b coef=%0d cv=%0b last=%0b",
                     $realtime, out_byte_out, out_byte_valid, out_coefficient_out,
                     out_coefficient_valid, out_last);
          end
        end
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [11:0] coef, input logic [7:0] pk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coefficient_in <= coef;
    in_byte_in <= pk;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    if (pred_dir) decompress_beats++;
    else compress_beats++;
    predict_codec_beat(coef, pk);
  endtask

  // Drop valid and let every owed result and any no-result beat drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mlkcc_pkg::cfg_idx_t idx, input logic [1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mlkcc_pkg::CFG_DIRECTION) pred_dir = value[0];
    else pred_mode = value;
    pred_buf = 0;
    pred_cnt = 0;
    reg_writes++;
  endtask

  function automatic logic [11:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(mlkcc_pkg::KyberQ + 1, 4095));
    return 12'($urandom_range(0, mlkcc_pkg::KyberQ));
  endfunction

  // Reset values: compress at 4 bits, rounding edges and out-of-range input
  task automatic test_reset_state();
    send_beat(12'd0, 8'h00);
    send_beat(12'(mlkcc_pkg::KyberQ), 8'hFF);
    send_beat(12'hFFF, 8'h00);
    send_beat(12'd1664, 8'hFF);
  endtask

  // One-bit compress across both rounding thresholds and beyond q
  task automatic test_compress_one_bit();
    write_reg(mlkcc_pkg::CFG_BIT_MODE, mlkcc_pkg::MODE_D1);
    send_beat(12'd832, 8'h00);
    send_beat(12'd833, 8'h00);
    send_beat(12'd2496, 8'h00);
    send_beat(12'd2497, 8'h00);
    send_beat(12'd0, 8'h00);
    send_beat(12'(mlkcc_pkg::KyberQ), 8'h00);
    send_beat(12'(mlkcc_pkg::KyberQ + 1), 8'h00);
    send_beat(12'hFFF, 8'h00);
  endtask

  // Spare mode code packs 5 bits; leave bits pending for the next write to drop
  task automatic test_spare_mode();
    write_reg(mlkcc_pkg::CFG_BIT_MODE, MODE_SPARE);
    send_beat(12'hFFF, 8'h00);
    send_beat(12'd3328, 8'h00);
    send_beat(12'd104, 8'h00);
    send_beat(12'd105, 8'h00);
  endtask

  // Decompress at every width: all-ones and all-zeros bytes at 1 and 5 bits, mixed bytes at 4 and 5 bits
  task automatic test_decompress();
    write_reg(mlkcc_pkg::CFG_DIRECTION, DIR_DECOMPRESS);
    write_reg(mlkcc_pkg::CFG_BIT_MODE, mlkcc_pkg::MODE_D1);
    send_beat(12'd0, 8'hFF);
    send_beat(12'hFFF, 8'h00);
    write_reg(mlkcc_pkg::CFG_BIT_MODE, mlkcc_pkg::MODE_D4);
    send_beat(12'd0, 8'h0F);
    send_beat(12'd0, 8'hF0);
    write_reg(mlkcc_pkg::CFG_BIT_MODE, mlkcc_pkg::MODE_D5);
    send_beat(12'd0, 8'hFF);
    send_beat(12'd0, 8'h00);
    send_beat(12'd0, 8'hA5);
  endtask

  // Random settings and random beats under the given idle rates
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned segments, input int unsigned beats);
    logic dir;
    logic [1:0] mode;
    int unsigned pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int s = 0; s < segments; s++) begin
      dir = 1'($urandom_range(0, 1));
      mode = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 2);
      // the upper data bit of a direction write is random and must be ignored
      if (pick != 2) write_reg(mlkcc_pkg::CFG_DIRECTION, {1'($urandom_range(0, 1)), dir});
      if (pick != 1) write_reg(mlkcc_pkg::CFG_BIT_MODE, mode);
      for (int i = 0; i < beats; i++) send_beat(rand_coef(), 8'($urandom));
    end
  endtask

  // Long output hold-off while bytes keep coming, so the input backs up
  task automatic test_output_holdoff();
    write_reg(mlkcc_pkg::CFG_DIRECTION, DIR_DECOMPRESS);
    write_reg(mlkcc_pkg::CFG_BIT_MODE, mlkcc_pkg::MODE_D1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_req = 150;
    for (int i = 0; i < 10; i++) send_beat(rand_coef(), 8'($urandom));
  endtask

  initial begin
    int unsigned waited;
    pred_dir = 1'b0;
    pred_mode = mlkcc_pkg::MODE_D4;
    pred_buf = 0;
    pred_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_compress_one_bit();
    test_spare_mode();
    test_decompress();
    test_random_traffic(28, 82, 4, 7);
    test_random_traffic(82, 28, 4, 7);
    test_random_traffic(0, 0, 4, 7);
    test_output_holdoff();

    // Drain, with a cap so a lost result shows up as a leftover
    in_valid <= 1'b0;
    waited = 0;
    while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      waited++;
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      fail_count += owed_results.size();
      $display("%0d owed results never arrived", owed_results.size());
    end

    $display("Covered %0d compress and %0d decompress beats over %0d register writes;",
             compress_beats, decompress_beats, reg_writes);
    $display("checked %0d packed bytes and %0d coefficients, input stalled %0d cycles.",
             bytes_seen, coefs_seen, input_stall_cycles);
    if (fail_count == 0) begin
      $display("tb_mlkem_coeff_compress_pack passed");
    end else begin
      $display("tb_mlkem_coeff_compress_pack failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb_mlkem_coeff_compress_pack failed");
    $finish;
  end

endmodule
